@@ rtl/adpe_pkg.sv @@
// Shared types and constants for the aperture disk pixel exclusion block.
`default_nettype none

package adpe_pkg;

  localparam int MAX_COLS_DEF  = 512;
  localparam int MAX_ROWS_DEF  = 512;
  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int SRC_W  = 19;
  localparam int PIX_W  = 9;
  localparam int IMG_W  = 10;
  localparam int RAD_W  = 15;
  localparam int CFG_DW = 15;
  localparam int CNT_W  = 15;
  localparam int IDX_W  = 2;

  // Coordinate width that covers the largest supported image side.
  localparam int CW   = 12;
  // Bound arithmetic, offset arithmetic and squared distance widths.
  localparam int BW   = 24;
  localparam int DW   = 32;
  localparam int SQ_W = 30;

  localparam logic [IMG_W-1:0] IMG_RESET    = 10'd512;
  localparam logic [RAD_W-1:0] RADIUS_LIMIT = 15'd16384;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_APERTURE_RADIUS = 2'd2
  } reg_index_t;

  typedef struct packed {
    action_t                  action;
    logic                     box_empty;
    logic                     in_image;
    logic [CW-1:0]            x_lo;
    logic [CW-1:0]            x_hi;
    logic [CW-1:0]            y_lo;
    logic [CW-1:0]            y_hi;
    logic signed [SRC_W-1:0]  src_x;
    logic signed [SRC_W-1:0]  src_y;
    logic [CW-1:0]            col;
    logic [CW-1:0]            row;
    logic [SQ_W-1:0]          r2;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/aperture_disk_pixel_exclusion.sv @@
// Top level of the aperture disk pixel exclusion block.
//
// Requests enter on start while busy is low: action, source_x/source_y
// (signed fixed point with FRAC_BITS fraction bits) and pixel_col/pixel_row.
// Each request yields one result, shown for one cycle with done high:
// is_excluded answers a query, marked_count gives the pixels an add set.
// The configuration port (cfg_write, cfg_index, cfg_data) writes image width,
// image height and aperture radius; write it only when idle.
// A request is registered in the front end, then waits in a two-entry queue
// until the map engine takes it. Mark, and an add whose clipped box is empty,
// are answered as the engine takes them; a query first reads its map row. Add
// walks its clipped bounding box at one pixel per cycle through an offset
// stage, a square stage and a compare. Clear sweeps the map one row per cycle.
// The map engine works on one request at a time; the queue holds later ones.
// After reset the map is cleared by the same sweep, with busy held high;
// configuration writes are taken during it.
// Results cannot be held off by the receiver.
`default_nettype none

module aperture_disk_pixel_exclusion #(
  parameter int MAX_COLS  = adpe_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = adpe_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = adpe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        action,
  input  wire logic signed [adpe_pkg::SRC_W-1:0] source_x,
  input  wire logic signed [adpe_pkg::SRC_W-1:0] source_y,
  input  wire logic [adpe_pkg::PIX_W-1:0]        pixel_col,
  input  wire logic [adpe_pkg::PIX_W-1:0]        pixel_row,
  input  wire logic                              cfg_write,
  input  wire logic [adpe_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [adpe_pkg::CFG_DW-1:0]       cfg_data,
  output logic                                   done,
  output logic                                   is_excluded,
  output logic [adpe_pkg::CNT_W-1:0]             marked_count
);
  import adpe_pkg::*;

  cmd_t front_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic clearing;

  adpe_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .source_x  (source_x),
    .source_y  (source_y),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .clearing  (clearing),
    .busy      (busy),
    .push      (push),
    .cmd       (front_cmd)
  );

  adpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .pop   (pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  adpe_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .is_excluded  (is_excluded),
    .marked_count (marked_count)
  );

endmodule

`default_nettype wire

@@ rtl/adpe_front.sv @@
// Front end: configuration registers, request capture and bounding box setup.
`default_nettype none

module adpe_front #(
  parameter int MAX_COLS  = adpe_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = adpe_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = adpe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [1:0]                       action,
  input  wire logic signed [adpe_pkg::SRC_W-1:0] source_x,
  input  wire logic signed [adpe_pkg::SRC_W-1:0] source_y,
  input  wire logic [adpe_pkg::PIX_W-1:0]       pixel_col,
  input  wire logic [adpe_pkg::PIX_W-1:0]       pixel_row,
  input  wire logic                             cfg_write,
  input  wire logic [adpe_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [adpe_pkg::CFG_DW-1:0]      cfg_data,
  input  wire logic                             q_full,
  input  wire logic                             clearing,
  output logic                                  busy,
  output logic                                  push,
  output adpe_pkg::cmd_t                        cmd
);
  import adpe_pkg::*;

  localparam int ONE_Q  = 1 << FRAC_BITS;
  localparam int HALF_Q = 1 << (FRAC_BITS - 1);

  logic [IMG_W-1:0] image_width;
  logic [IMG_W-1:0] image_height;
  logic [RAD_W-1:0] aperture_radius;

  logic                    f_valid;
  logic [1:0]              f_action;
  logic signed [SRC_W-1:0] f_x;
  logic signed [SRC_W-1:0] f_y;
  logic [PIX_W-1:0]        f_col;
  logic [PIX_W-1:0]        f_row;

  logic [RAD_W-1:0]     r_eff;
  logic signed [BW-1:0] r_s, x_s, y_s, w_eff, h_eff;
  logic signed [BW-1:0] x_lo_raw, x_hi_raw, y_lo_raw, y_hi_raw;
  logic signed [BW-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [BW-1:0] col_s, row_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= IMG_RESET;
      image_height    <= IMG_RESET;
      aperture_radius <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[IMG_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[IMG_W-1:0];
        REG_APERTURE_RADIUS: aperture_radius <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = f_valid | q_full | clearing;
  assign push = f_valid & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (start && !busy) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      f_action <= action;
      f_x      <= source_x;
      f_y      <= source_y;
      f_col    <= pixel_col;
      f_row    <= pixel_row;
    end
  end

  // The box runs from ceil((p - r - half) / one) to floor((p + r - half) / one).
  always_comb begin
    r_eff = (aperture_radius > RADIUS_LIMIT) ? RADIUS_LIMIT : aperture_radius;
    r_s   = signed'({{(BW-RAD_W){1'b0}}, r_eff});
    x_s   = BW'(f_x);
    y_s   = BW'(f_y);
    w_eff = (image_width > MAX_COLS) ? BW'(MAX_COLS)
                                     : signed'({{(BW-IMG_W){1'b0}}, image_width});
    h_eff = (image_height > MAX_ROWS) ? BW'(MAX_ROWS)
                                      : signed'({{(BW-IMG_W){1'b0}}, image_height});

    x_lo_raw = (x_s - r_s + BW'(ONE_Q - HALF_Q - 1)) >>> FRAC_BITS;
    x_hi_raw = (x_s + r_s - BW'(HALF_Q)) >>> FRAC_BITS;
    y_lo_raw = (y_s - r_s + BW'(ONE_Q - HALF_Q - 1)) >>> FRAC_BITS;
    y_hi_raw = (y_s + r_s - BW'(HALF_Q)) >>> FRAC_BITS;

    x_lo = (x_lo_raw < 0) ? BW'(0) : x_lo_raw;
    y_lo = (y_lo_raw < 0) ? BW'(0) : y_lo_raw;
    x_hi = (x_hi_raw > w_eff - BW'(1)) ? w_eff - BW'(1) : x_hi_raw;
    y_hi = (y_hi_raw > h_eff - BW'(1)) ? h_eff - BW'(1) : y_hi_raw;

    col_s = signed'({{(BW-PIX_W){1'b0}}, f_col});
    row_s = signed'({{(BW-PIX_W){1'b0}}, f_row});

    cmd.action    = action_t'(f_action);
    cmd.box_empty = (x_lo > x_hi) || (y_lo > y_hi);
    cmd.in_image  = (col_s < w_eff) && (row_s < h_eff);
    cmd.x_lo      = x_lo[CW-1:0];
    cmd.x_hi      = x_hi[CW-1:0];
    cmd.y_lo      = y_lo[CW-1:0];
    cmd.y_hi      = y_hi[CW-1:0];
    cmd.src_x     = f_x;
    cmd.src_y     = f_y;
    cmd.col       = {{(CW-PIX_W){1'b0}}, f_col};
    cmd.row       = {{(CW-PIX_W){1'b0}}, f_row};
    cmd.r2        = SQ_W'(r_eff) * SQ_W'(r_eff);
  end

endmodule

`default_nettype wire

@@ rtl/adpe_queue.sv @@
// Short command queue between the front end and the map engine.
`default_nettype none

module adpe_queue #(
  parameter int DEPTH = adpe_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire adpe_pkg::cmd_t wdata,
  input  wire logic           pop,
  output adpe_pkg::cmd_t      rdata,
  output logic                full,
  output logic                empty
);
  import adpe_pkg::*;

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t            entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign full    = (fill == CNTW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNTW'(1);
        2'b01:   fill <= fill - CNTW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/adpe_back.sv @@
// Map engine: exclusion bit memory, disk walk pipeline, query and clear sweep.
`default_nettype none

module adpe_back #(
  parameter int MAX_COLS  = adpe_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = adpe_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = adpe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire adpe_pkg::cmd_t            head,
  input  wire logic                      q_empty,
  output logic                           pop,
  output logic                           clearing,
  output logic                           done,
  output logic                           is_excluded,
  output logic [adpe_pkg::CNT_W-1:0]     marked_count
);
  import adpe_pkg::*;

  localparam int HALF_Q = 1 << (FRAC_BITS - 1);
  localparam int RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_READ  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_row;

  state_t          state;
  cmd_t            c;
  logic [CW-1:0]   xi;
  logic [CW-1:0]   yi;
  logic [RAW-1:0]  clr_row;
  logic [CNT_W-1:0] count;

  logic             p1_valid;
  logic [CW-1:0]    p1_x, p1_y;
  logic [RAD_W-1:0] p1_dx, p1_dy;
  logic             p2_valid;
  logic [CW-1:0]    p2_x, p2_y;
  logic [SQ_W-1:0]  p2_sqx, p2_sqy;

  logic signed [DW-1:0] dx, dy, dx_abs, dy_abs;
  logic [SQ_W:0]        dist2;
  logic                 in_disk;
  logic                 hit;
  logic                 set_en;
  logic [CW-1:0]        set_row, set_col;
  logic                 clr_en;
  logic                 rd_en;

  assign pop    = (state == S_IDLE) && !q_empty;
  assign clr_en = (state == S_CLEAR);
  assign rd_en  = pop && (head.action == ACT_QUERY);

  // Offsets from the source to the pixel centre; the box keeps them within the radius.
  always_comb begin
    dx      = (signed'({{(DW-CW){1'b0}}, xi}) <<< FRAC_BITS) + DW'(HALF_Q) - DW'(c.src_x);
    dy      = (signed'({{(DW-CW){1'b0}}, yi}) <<< FRAC_BITS) + DW'(HALF_Q) - DW'(c.src_y);
    dx_abs  = (dx < 0) ? -dx : dx;
    dy_abs  = (dy < 0) ? -dy : dy;
    dist2   = (SQ_W+1)'(p2_sqx) + (SQ_W+1)'(p2_sqy);
    in_disk = (dist2 <= (SQ_W+1)'(c.r2));
    hit     = p2_valid && in_disk;

    if (hit) begin
      set_en  = 1'b1;
      set_row = p2_y;
      set_col = p2_x;
    end else begin
      set_en  = pop && (head.action == ACT_MARK) && head.in_image;
      set_row = head.row;
      set_col = head.col;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_row] <= '0;
    end else if (set_en) begin
      mem[set_row[RAW-1:0]][set_col[CAW-1:0]] <= 1'b1;
    end
    if (rd_en) begin
      rd_row <= mem[head.row[RAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    p1_x   <= xi;
    p1_y   <= yi;
    p1_dx  <= dx_abs[RAD_W-1:0];
    p1_dy  <= dy_abs[RAD_W-1:0];
    p2_x   <= p1_x;
    p2_y   <= p1_y;
    p2_sqx <= SQ_W'(p1_dx) * SQ_W'(p1_dx);
    p2_sqy <= SQ_W'(p1_dy) * SQ_W'(p1_dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clearing <= 1'b1;
      clr_row  <= '0;
      done     <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      done     <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= p1_valid;
      if (hit && count != '1) begin
        count <= count + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            c <= head;
            case (head.action)
              ACT_ADD: begin
                count <= '0;
                xi    <= head.x_lo;
                yi    <= head.y_lo;
                if (head.box_empty) begin
                  done         <= 1'b1;
                  is_excluded  <= 1'b0;
                  marked_count <= '0;
                end else begin
                  state <= S_WALK;
                end
              end
              ACT_MARK: begin
                done         <= 1'b1;
                is_excluded  <= 1'b0;
                marked_count <= '0;
              end
              ACT_QUERY: begin
                state <= S_READ;
              end
              ACT_CLEAR: begin
                clr_row <= '0;
                state   <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          p1_valid <= 1'b1;
          if (xi == c.x_hi) begin
            xi <= c.x_lo;
            if (yi == c.y_hi) begin
              state <= S_DRAIN;
            end else begin
              yi <= yi + CW'(1);
            end
          end else begin
            xi <= xi + CW'(1);
          end
        end
        S_DRAIN: begin
          // The count is final once the last pixel has left the compare stage.
          if (!p1_valid && !p2_valid) begin
            done         <= 1'b1;
            is_excluded  <= 1'b0;
            marked_count <= count;
            state        <= S_IDLE;
          end
        end
        S_READ: begin
          done         <= 1'b1;
          is_excluded  <= rd_row[c.col[CAW-1:0]] & c.in_image;
          marked_count <= '0;
          state        <= S_IDLE;
        end
        S_CLEAR: begin
          if (clr_row == RAW'(MAX_ROWS - 1)) begin
            state    <= S_IDLE;
            clearing <= 1'b0;
            // The sweep after reset answers no request.
            if (!clearing) begin
              done         <= 1'b1;
              is_excluded  <= 1'b0;
              marked_count <= '0;
            end
          end else begin
            clr_row <= clr_row + RAW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
